>>> rtl/ngh_pkg.sv
`default_nettype none

package ngh_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 24;
	localparam int GAIN_W   = 17;
	localparam int COEF_W   = 16;
	localparam int HOLD_W   = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Channels that feed the linked peak detector (1 = left only).
	localparam int CHANNELS = 2;

	// Unity gain in Q16.
	localparam logic [GAIN_W-1:0] UNITY = 17'h10000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES    = 3'd4;

	// Configuration reset values
	localparam logic                  RST_GATE_ENABLE    = 1'b0;
	localparam logic [SAMPLE_W-1:0]   RST_OPEN_THRESHOLD = 24'd839;
	localparam logic [COEF_W-1:0]     RST_ATTACK_COEF    = 16'hFFFF;
	localparam logic [COEF_W-1:0]     RST_RELEASE_COEF   = 16'hFFFF;
	localparam logic [HOLD_W-1:0]     RST_HOLD_FRAMES    = 18'd0;

	// Microprogram step addresses
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_IDLE   = 3'd0;
	localparam step_t S_DECIDE = 3'd1;
	localparam step_t S_GAIN   = 3'd2;
	localparam step_t S_LEFT   = 3'd3;
	localparam step_t S_RIGHT  = 3'd4;

	// Operand selection for the shared multiplier
	typedef enum logic [1:0] {
		MS_GAIN  = 2'd0,
		MS_LEFT  = 2'd1,
		MS_RIGHT = 2'd2
	} mul_src_t;

	// Branch conditions
	typedef enum logic [1:0] {
		C_ALWAYS   = 2'd0,
		C_ACCEPT   = 2'd1,
		C_BYPASS   = 2'd2,
		C_OUT_FREE = 2'd3
	} cond_t;

	// One control word of the microprogram
	typedef struct packed {
		logic     ld_in;
		logic     decide;
		mul_src_t msrc;
		logic     wr_gain;
		logic     wr_left;
		logic     push;
		cond_t    cond;
		step_t    jmp_t;
		step_t    jmp_f;
	} uword_t;

	// Control store: one word per step.
	function automatic uword_t rom(input step_t s);
		uword_t w;
		unique case (s)
			S_IDLE: begin
				w = '{ld_in: 1'b1, decide: 1'b0, msrc: MS_GAIN, wr_gain: 1'b0,
					wr_left: 1'b0, push: 1'b0, cond: C_ACCEPT,
					jmp_t: S_DECIDE, jmp_f: S_IDLE};
			end
			S_DECIDE: begin
				w = '{ld_in: 1'b0, decide: 1'b1, msrc: MS_GAIN, wr_gain: 1'b0,
					wr_left: 1'b0, push: 1'b0, cond: C_BYPASS,
					jmp_t: S_RIGHT, jmp_f: S_GAIN};
			end
			S_GAIN: begin
				w = '{ld_in: 1'b0, decide: 1'b0, msrc: MS_GAIN, wr_gain: 1'b1,
					wr_left: 1'b0, push: 1'b0, cond: C_ALWAYS,
					jmp_t: S_LEFT, jmp_f: S_LEFT};
			end
			S_LEFT: begin
				w = '{ld_in: 1'b0, decide: 1'b0, msrc: MS_LEFT, wr_gain: 1'b0,
					wr_left: 1'b1, push: 1'b0, cond: C_ALWAYS,
					jmp_t: S_RIGHT, jmp_f: S_RIGHT};
			end
			S_RIGHT: begin
				w = '{ld_in: 1'b0, decide: 1'b0, msrc: MS_RIGHT, wr_gain: 1'b0,
					wr_left: 1'b0, push: 1'b1, cond: C_OUT_FREE,
					jmp_t: S_IDLE, jmp_f: S_RIGHT};
			end
			default: begin
				w = '{ld_in: 1'b0, decide: 1'b0, msrc: MS_GAIN, wr_gain: 1'b0,
					wr_left: 1'b0, push: 1'b0, cond: C_ALWAYS,
					jmp_t: S_IDLE, jmp_f: S_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/noise_gate_with_hold.sv
// An accepted request passes the decide, gain, left and right steps (bypass: decide,
// right); no new one is taken before right pushes it. One shared 25x18 multiplier
// is stepped by the microprogram through the gain update, left and right scaling.
// Reset (arst_n low, asynchronous): registers return to their reset values, the
// gain goes to unity, the hold counter to zero and the output holds no request.
`default_nettype none

module noise_gate_with_hold (
	input  wire                                       clk,
	input  wire                                       arst_n,
	// Input frames
	input  wire                                       in_valid,
	output logic                                      in_stall,
	input  wire  signed [ngh_pkg::SAMPLE_W-1:0]       sample_left,
	input  wire  signed [ngh_pkg::SAMPLE_W-1:0]       sample_right,
	// Output frames
	output logic                                      out_valid,
	input  wire                                       out_stall,
	output logic signed [ngh_pkg::SAMPLE_W-1:0]       gated_left,
	output logic signed [ngh_pkg::SAMPLE_W-1:0]       gated_right,
	// Configuration write port
	input  wire                                       cfg_we,
	input  wire         [ngh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire         [ngh_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration registers
	logic                              enable_q;
	logic [ngh_pkg::SAMPLE_W-1:0]      thr_q;
	logic [ngh_pkg::COEF_W-1:0]        attack_q;
	logic [ngh_pkg::COEF_W-1:0]        release_q;
	logic [ngh_pkg::HOLD_W-1:0]        hold_frames_q;

	// Sequencer and datapath state
	ngh_pkg::step_t                    step_q;
	ngh_pkg::step_t                    step_d;
	ngh_pkg::uword_t                   uw;
	logic                              take;
	logic [ngh_pkg::GAIN_W-1:0]        gain_q;
	logic [ngh_pkg::HOLD_W-1:0]        hold_q;
	logic signed [ngh_pkg::SAMPLE_W-1:0] left_q;
	logic signed [ngh_pkg::SAMPLE_W-1:0] right_q;
	logic                              open_q;
	logic [ngh_pkg::COEF_W-1:0]        coef_q;
	logic [ngh_pkg::GAIN_W-1:0]        diff_q;
	logic signed [ngh_pkg::SAMPLE_W-1:0] left_res_q;
	logic                              out_valid_q;
	logic signed [ngh_pkg::SAMPLE_W-1:0] gated_left_q;
	logic signed [ngh_pkg::SAMPLE_W-1:0] gated_right_q;

	// Handshake terms
	logic                              in_accept;
	logic                              out_free;

	// Decision logic
	logic [ngh_pkg::SAMPLE_W-1:0]      abs_l;
	logic [ngh_pkg::SAMPLE_W-1:0]      abs_r;
	logic [ngh_pkg::SAMPLE_W-1:0]      peak;
	logic                              above;
	logic                              gate_open;

	// Shared multiplier
	logic signed [24:0]                mul_a;
	logic signed [17:0]                mul_b;
	logic signed [42:0]                mul_p;
	logic signed [42:0]                mul_r;
	logic [ngh_pkg::GAIN_W-1:0]        mul_sh;
	logic signed [ngh_pkg::SAMPLE_W-1:0] scaled;
	logic [ngh_pkg::GAIN_W-1:0]        gain_next;

	assign in_stall    = (step_q != ngh_pkg::S_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign gated_left  = gated_left_q;
	assign gated_right = gated_right_q;

	// Fetch the control word and resolve the branch.
	always_comb begin
		uw = ngh_pkg::rom(step_q);
		unique case (uw.cond)
			ngh_pkg::C_ALWAYS:   take = 1'b1;
			ngh_pkg::C_ACCEPT:   take = in_accept;
			ngh_pkg::C_BYPASS:   take = !enable_q;
			ngh_pkg::C_OUT_FREE: take = out_free;
			default:             take = 1'b1;
		endcase
		step_d = take ? uw.jmp_t : uw.jmp_f;
	end

	// Linked peak and the open or closed decision.
	always_comb begin
		abs_l = left_q[ngh_pkg::SAMPLE_W-1] ? $unsigned(-left_q) : $unsigned(left_q);
		abs_r = right_q[ngh_pkg::SAMPLE_W-1] ? $unsigned(-right_q) : $unsigned(right_q);
		peak  = ((ngh_pkg::CHANNELS >= 2) && (abs_r > abs_l)) ? abs_r : abs_l;
		above = (peak >= thr_q);
		gate_open = above || (hold_q != '0);
	end

	// Operand selection, multiply and the two result forms.
	always_comb begin
		unique case (uw.msrc)
			ngh_pkg::MS_GAIN: begin
				mul_a = {9'd0, coef_q};
				mul_b = {1'b0, diff_q};
			end
			ngh_pkg::MS_LEFT: begin
				mul_a = {left_q[ngh_pkg::SAMPLE_W-1], left_q};
				mul_b = {1'b0, gain_q};
			end
			ngh_pkg::MS_RIGHT: begin
				mul_a = {right_q[ngh_pkg::SAMPLE_W-1], right_q};
				mul_b = {1'b0, gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p     = mul_a * mul_b;
		mul_r     = mul_p + 43'sd32768;
		scaled    = mul_r[39:16];
		mul_sh    = mul_p[32:16];
		gain_next = open_q ? (ngh_pkg::UNITY - mul_sh) : mul_sh;
	end

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= ngh_pkg::RST_GATE_ENABLE;
			thr_q         <= ngh_pkg::RST_OPEN_THRESHOLD;
			attack_q      <= ngh_pkg::RST_ATTACK_COEF;
			release_q     <= ngh_pkg::RST_RELEASE_COEF;
			hold_frames_q <= ngh_pkg::RST_HOLD_FRAMES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ngh_pkg::REG_GATE_ENABLE:    enable_q      <= cfg_data[0];
				ngh_pkg::REG_OPEN_THRESHOLD: thr_q         <= cfg_data;
				ngh_pkg::REG_ATTACK_COEF:    attack_q      <= cfg_data[ngh_pkg::COEF_W-1:0];
				ngh_pkg::REG_RELEASE_COEF:   release_q     <= cfg_data[ngh_pkg::COEF_W-1:0];
				ngh_pkg::REG_HOLD_FRAMES:    hold_frames_q <= cfg_data[ngh_pkg::HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Step counter, gain and hold state, output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ngh_pkg::S_IDLE;
			gain_q      <= ngh_pkg::UNITY;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (uw.decide && enable_q) begin
				if (above) begin
					hold_q <= hold_frames_q;
				end else if (hold_q != '0) begin
					hold_q <= hold_q - 1'b1;
				end
			end
			if (uw.wr_gain) begin
				gain_q <= gain_next;
			end
			if (uw.push && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (uw.ld_in && in_accept) begin
			left_q  <= sample_left;
			right_q <= sample_right;
		end
		if (uw.decide) begin
			open_q <= gate_open;
			if (gate_open) begin
				coef_q <= (gain_q < ngh_pkg::UNITY) ? attack_q : release_q;
				diff_q <= ngh_pkg::UNITY - gain_q;
			end else begin
				coef_q <= release_q;
				diff_q <= gain_q;
			end
		end
		if (uw.wr_left) begin
			left_res_q <= scaled;
		end
		if (uw.push && out_free) begin
			gated_left_q  <= enable_q ? left_res_q : left_q;
			gated_right_q <= enable_q ? scaled : right_q;
		end
	end

	// The smoothed gain never leaves the range zero to unity.
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= ngh_pkg::UNITY)
		else $error("gain above unity");

	// The step counter stays inside the program.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ngh_pkg::S_RIGHT)
		else $error("step counter outside the program");

	// An accepted request always starts with the decision step.
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> step_q == ngh_pkg::S_DECIDE)
		else $error("accepted request did not reach the decision step");

	// Below threshold, the hold counter counts down by one and stops at zero.
	a_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.decide && enable_q && !above) |=>
		(hold_q == (($past(hold_q) == '0) ? '0 : $past(hold_q) - 1'b1)))
		else $error("hold counter did not count down");

	// In bypass the gain never moves.
	a_bypass_gain: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |=> $stable(gain_q))
		else $error("gain changed while bypassed");

endmodule

`default_nettype wire

>>> tb/gate_result_checker.sv
`timescale 1ns / 100ps

module gate_result_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [ngh_pkg::SAMPLE_W-1:0] sample_left,
	input  logic signed [ngh_pkg::SAMPLE_W-1:0] sample_right,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [ngh_pkg::SAMPLE_W-1:0] gated_left,
	input  logic signed [ngh_pkg::SAMPLE_W-1:0] gated_right,
	input  logic                                cfg_we,
	input  logic [ngh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ngh_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                  mismatches,
	output int                                  outstanding,
	output int                                  frames_compared,
	output int                                  frames_held
);

	typedef struct packed {
		logic signed [ngh_pkg::SAMPLE_W-1:0] left;
		logic signed [ngh_pkg::SAMPLE_W-1:0] right;
	} stereo_t;

	localparam logic [ngh_pkg::GAIN_W-1:0] FULL_GAIN = 17'h10000;

	// Shadow copy of the gate settings, tracked from the write port.
	logic                          gate_on;
	logic [ngh_pkg::SAMPLE_W-1:0]  open_level;
	logic [ngh_pkg::COEF_W-1:0]    rise_coef;
	logic [ngh_pkg::COEF_W-1:0]    fall_coef;
	logic [ngh_pkg::HOLD_W-1:0]    hold_reload;

	// Shadow copy of the gain smoother and the hold counter.
	logic [ngh_pkg::GAIN_W-1:0]    smooth_gain;
	logic [ngh_pkg::HOLD_W-1:0]    hold_left;

	// Gated frames still owed by the block, oldest first.
	stereo_t gated_due[$];

	// Multiply by a Q16 gain and round half up, i.e. floor(s * g / 65536 + 0.5).
	function automatic logic signed [ngh_pkg::SAMPLE_W-1:0] apply_gain(
		input logic signed [ngh_pkg::SAMPLE_W-1:0] s,
		input logic [ngh_pkg::GAIN_W-1:0] g);
		longint prod;
		longint scaled;
		prod = longint'(s) * longint'(g) + 64'sd32768;
		scaled = prod >>> 16;
		return scaled[ngh_pkg::SAMPLE_W-1:0];
	endfunction

	// Advance the gate by one frame and return the frame it should emit.
	function automatic stereo_t gate_frame(input stereo_t x);
		logic [ngh_pkg::SAMPLE_W:0] mag_l;
		logic [ngh_pkg::SAMPLE_W:0] mag_r;
		logic [ngh_pkg::SAMPLE_W:0] peak;
		logic                       opening;
		logic [ngh_pkg::COEF_W-1:0] k;
		logic [32:0]                prod;
		stereo_t                    y;
		if (!gate_on) begin
			return x;
		end
		mag_l = x.left[ngh_pkg::SAMPLE_W-1] ? 25'd0 - {x.left[ngh_pkg::SAMPLE_W-1], x.left}
			: {1'b0, x.left};
		mag_r = x.right[ngh_pkg::SAMPLE_W-1] ? 25'd0 - {x.right[ngh_pkg::SAMPLE_W-1], x.right}
			: {1'b0, x.right};
		peak = mag_l;
		if (ngh_pkg::CHANNELS >= 2 && mag_r > peak) begin
			peak = mag_r;
		end

		// Open on a loud frame, ride out the hold, otherwise close.
		if (peak >= {1'b0, open_level}) begin
			opening = 1'b1;
			hold_left = hold_reload;
		end else if (hold_left != '0) begin
			opening = 1'b1;
			hold_left = hold_left - 1'b1;
			frames_held++;
		end else begin
			opening = 1'b0;
		end

		// One-pole smoother toward unity or zero, truncated toward the target.
		if (opening) begin
			k = (smooth_gain < FULL_GAIN) ? rise_coef : fall_coef;
			prod = 33'(k) * 33'(FULL_GAIN - smooth_gain);
			smooth_gain = FULL_GAIN - 17'(prod >> 16);
		end else begin
			prod = 33'(fall_coef) * 33'(smooth_gain);
			smooth_gain = 17'(prod >> 16);
		end

		y.left = apply_gain(x.left, smooth_gain);
		y.right = apply_gain(x.right, smooth_gain);
		return y;
	endfunction

	// Compare results first, then track settings, then predict new requests.
	always @(posedge clk or negedge arst_n) begin
		stereo_t got;
		stereo_t want;
		if (!arst_n) begin
			gate_on = 1'b0;
			open_level = 24'd839;
			rise_coef = 16'hFFFF;
			fall_coef = 16'hFFFF;
			hold_reload = '0;
			smooth_gain = FULL_GAIN;
			hold_left = '0;
			gated_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				got.left = gated_left;
				got.right = gated_right;
				if (gated_due.size() == 0) begin
					mismatches++;
					$display("%0t: result (%0d, %0d) arrived with no frame waiting",
						$time, got.left, got.right);
				end else begin
					want = gated_due.pop_front();
					frames_compared++;
					if (got.left !== want.left) begin
						mismatches++;
						$display("%0t: gated_left expected %0d, got %0d",
							$time, want.left, got.left);
					end
					if (got.right !== want.right) begin
						mismatches++;
						$display("%0t: gated_right expected %0d, got %0d",
							$time, want.right, got.right);
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					ngh_pkg::REG_GATE_ENABLE:    gate_on = cfg_data[0];
					ngh_pkg::REG_OPEN_THRESHOLD: open_level = cfg_data[ngh_pkg::SAMPLE_W-1:0];
					ngh_pkg::REG_ATTACK_COEF:    rise_coef = cfg_data[ngh_pkg::COEF_W-1:0];
					ngh_pkg::REG_RELEASE_COEF:   fall_coef = cfg_data[ngh_pkg::COEF_W-1:0];
					ngh_pkg::REG_HOLD_FRAMES:    hold_reload = cfg_data[ngh_pkg::HOLD_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				got.left = sample_left;
				got.right = sample_right;
				gated_due.push_back(gate_frame(got));
			end
		end
		outstanding = gated_due.size();
	end

endmodule

>>> tb/tb_noise_gate_with_hold.sv
`timescale 1ns / 100ps

module tb_noise_gate_with_hold;

	typedef logic signed [ngh_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic [ngh_pkg::SAMPLE_W-1:0]        level_t;
	typedef logic [ngh_pkg::COEF_W-1:0]          coef_t;
	typedef logic [ngh_pkg::HOLD_W-1:0]          hold_t;
	typedef logic [ngh_pkg::CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [ngh_pkg::CFG_DATA_W-1:0]      cfg_data_t;

	// Index with no register behind it; writes there must change nothing.
	localparam cfg_idx_t REG_SPARE = 3'd7;

	localparam int RX_HOLD_CYCLES = 120;
	localparam int IDLE_LIMIT     = 2000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 67;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      in_valid     = 1'b0;
	sample_t   sample_left  = '0;
	sample_t   sample_right = '0;
	logic      out_stall    = 1'b0;
	logic      cfg_we       = 1'b0;
	cfg_idx_t  cfg_index    = '0;
	cfg_data_t cfg_data     = '0;

	logic      in_stall;
	logic      out_valid;
	sample_t   gated_left;
	sample_t   gated_right;

	int mismatch_count;
	int outstanding;
	int compared_count;
	int held_count;

	int          frames_sent   = 0;
	int          settings_used = 0;
	int unsigned level_now     = 839;
	bit          tx_gaps       = 1'b0;
	bit          rx_stalls     = 1'b0;
	bit          rx_hold_req   = 1'b0;

	noise_gate_with_hold i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gated_left   (gated_left),
		.gated_right  (gated_right),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	gate_result_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_left     (sample_left),
		.sample_right    (sample_right),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.gated_left      (gated_left),
		.gated_right     (gated_right),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatch_count),
		.outstanding     (outstanding),
		.frames_compared (compared_count),
		.frames_held     (held_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Stop the run if no request moves on either side for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: watchdog expired after %0d quiet cycles", $time, IDLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stalls, occasional bursts, and one long hold-off on request.
	initial begin
		int unsigned r;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if (!rx_stalls) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_stall <= 1'b0;
				end else if (r < 93) begin
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(6, 30)) @(negedge clk);
				end
			end
		end
	end

	function automatic int pick_gap();
		int unsigned r;
		if (!tx_gaps) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return int'($urandom_range(1, 3));
		end
		return int'($urandom_range(6, 30));
	endfunction

	// Give a magnitude a random sign; full scale is only reachable as negative.
	function automatic sample_t with_sign(input int unsigned mag);
		logic [31:0] v;
		if (mag >= 32'h800000) begin
			return 24'sh800000;
		end
		v = $urandom_range(0, 1) ? 32'd0 - mag : mag;
		return v[ngh_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic sample_t quiet_sample();
		if (level_now == 0) begin
			return sample_t'($urandom());
		end
		return with_sign($urandom_range(0, level_now - 1));
	endfunction

	function automatic sample_t loud_sample();
		return with_sign($urandom_range(level_now, 32'h800000));
	endfunction

	function automatic sample_t extreme_sample();
		case ($urandom_range(0, 4))
			0:       return 24'sh800000;
			1:       return 24'sh7FFFFF;
			2:       return 24'sh000000;
			3:       return 24'shFFFFFF;
			default: return 24'sh000001;
		endcase
	endfunction

	// Offer one frame after an optional gap and wait for it to be taken.
	task automatic send_frame(input sample_t l, input sample_t r, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample_left <= l;
		sample_right <= r;
		frames_sent++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering and wait until every gated frame has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_gate(input logic en, input level_t level,
		input coef_t rise, input coef_t fall, input hold_t hold);
		write_reg(ngh_pkg::REG_GATE_ENABLE, cfg_data_t'(en));
		write_reg(ngh_pkg::REG_OPEN_THRESHOLD, cfg_data_t'(level));
		write_reg(ngh_pkg::REG_ATTACK_COEF, cfg_data_t'(rise));
		write_reg(ngh_pkg::REG_RELEASE_COEF, cfg_data_t'(fall));
		write_reg(ngh_pkg::REG_HOLD_FRAMES, cfg_data_t'(hold));
		level_now = 32'(level);
		settings_used++;
	endtask

	function automatic coef_t pick_coef();
		case ($urandom_range(0, 3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return coef_t'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic random_settings();
		logic   en;
		level_t level;
		hold_t  hold;
		en = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 5))
			0:       level = 24'd0;
			1:       level = 24'h800000;
			2, 3:    level = level_t'($urandom_range(1, 4096));
			4:       level = level_t'($urandom_range(1, 32'h800000));
			default: level = level_t'($urandom_range(4096, 1 << 20));
		endcase
		case ($urandom_range(0, 4))
			0:       hold = '0;
			1:       hold = 18'h3FFFF;
			default: hold = hold_t'($urandom_range(1, 8));
		endcase
		set_gate(en, level, pick_coef(), pick_coef(), hold);
	endtask

	// Stimulus: directed corners first, then phases of bursty random audio.
	initial begin
		sample_t     l;
		sample_t     r;
		int unsigned choice;
		int          run_left;
		bit          loud;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Bypass after reset: full-scale samples must pass untouched.
		send_frame(24'sh7FFFFF, 24'sh800000, 0);
		send_frame(24'sh800000, 24'sh7FFFFF, 0);
		send_frame(24'sh000000, 24'shFFFFFF, 0);
		send_frame(24'sh000001, 24'sh555555, 0);
		drain();

		// Instant attack, slowest release, two frames of hold.
		set_gate(1'b1, 24'd1000, 16'h0000, 16'hFFFF, 18'd2);
		send_frame(24'sh000000, 24'sh000000, 0);
		send_frame(-24'sd1000, 24'sd3, 0);
		send_frame(24'sd5, -24'sd999, 0);
		send_frame(24'sd5, 24'sd5, 0);
		send_frame(24'sd7, 24'sd8, 0);
		// Only the right channel is loud; the linked peak must still open the gate.
		send_frame(24'sd3, 24'sd1000, 0);
		drain();

		// A zero threshold keeps the gate open; the spare index must be ignored.
		set_gate(1'b1, 24'd0, 16'hFFFF, 16'h0000, 18'd0);
		write_reg(REG_SPARE, 24'hFFFFFF);
		send_frame(24'sh000000, 24'sh000000, 0);
		send_frame(24'sh000000, 24'sh800000, 0);
		drain();

		// Threshold at full scale: only the most negative sample opens the gate.
		// Half gain checks that rounding goes half up on both signs.
		set_gate(1'b1, 24'h800000, 16'hFFFF, 16'h8000, 18'd0);
		send_frame(24'sd3, -24'sd3, 0);
		send_frame(24'sh7FFFFF, 24'sh7FFFFF, 0);
		send_frame(24'sh800000, 24'sh000000, 0);
		send_frame(24'sh800000, 24'sh800000, 0);
		drain();

		// Bypass again with the smoother state left mid-way.
		set_gate(1'b0, 24'd50, 16'h1234, 16'hFEDC, 18'd3);
		send_frame(24'sd100, -24'sd100, 0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			if (p == 0) begin
				set_gate(1'b1, level_t'($urandom_range(1, 4096)), 16'h0000, 16'h0000,
					18'h3FFFF);
			end else begin
				random_settings();
			end
			// One phase runs with no idling on either side.
			tx_gaps = (p != 1) && ($urandom_range(0, 3) != 0);
			rx_stalls = (p != 1) && ($urandom_range(0, 3) != 0);
			if (p == 2) begin
				rx_hold_req = 1'b1;
			end
			loud = 1'b0;
			run_left = 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == PHASE_ITEMS / 2) begin
					drain();
				end
				if (run_left == 0) begin
					loud = !loud;
					run_left = loud ? $urandom_range(1, 6) : $urandom_range(1, 12);
				end
				run_left--;
				choice = $urandom_range(0, 99);
				if (choice < 80) begin
					if (loud) begin
						if ($urandom_range(0, 1)) begin
							l = loud_sample();
							r = $urandom_range(0, 1) ? quiet_sample() : loud_sample();
						end else begin
							l = quiet_sample();
							r = loud_sample();
						end
					end else begin
						l = quiet_sample();
						r = quiet_sample();
					end
				end else if (choice < 92) begin
					l = sample_t'($urandom());
					r = sample_t'($urandom());
				end else begin
					l = extreme_sample();
					r = extreme_sample();
				end
				send_frame(l, r, pick_gap());
			end
		end

		drain();
		repeat (10) @(negedge clk);
		$display("Sent %0d frames under %0d gate settings; %0d results compared,",
			frames_sent, settings_used, compared_count);
		$display("%0d frames kept open by the hold counter alone.", held_count);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
